/* hdl/ubx_frame_filter_parser_assert.svh */
// Assertion macros used by the frame parser top level.
`ifndef UBX_FRAME_FILTER_PARSER_ASSERT_SVH
`define UBX_FRAME_FILTER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define UBXFFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubxffp assertion failed");

// Next-cycle implication, disabled while reset is low.
`define UBXFFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubxffp assertion failed");

`endif

/* hdl/ubxffp_pkg.sv */
// Types and constants of the frame filter parser.
package ubxffp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CLASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_0    = 3'd3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
  localparam logic [7:0] ACK_CLASS_RST   = 8'h05;

  localparam logic [3:0] PH_SYNC1  = 4'd0;
  localparam logic [3:0] PH_SYNC2  = 4'd1;
  localparam logic [3:0] PH_CLASS  = 4'd2;
  localparam logic [3:0] PH_ID     = 4'd3;
  localparam logic [3:0] PH_LEN_LO = 4'd4;
  localparam logic [3:0] PH_LEN_HI = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CK_A   = 4'd7;
  localparam logic [3:0] PH_CK_B   = 4'd8;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] cls;
    logic [7:0] id;
  } filter_entry_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } match_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] offset;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] length;
    logic [1:0]  entry;
  } result_t;

endpackage

/* hdl/ubxffp_match.sv */
// Priority filter match over the class and id of a frame.
module ubxffp_match #(
  parameter int FILTER_ENTRIES = 4
) (
  input  ubxffp_pkg::filter_entry_t entries [FILTER_ENTRIES],
  input  logic [7:0]                ack_class,
  input  logic [7:0]                cls,
  input  logic [7:0]                id,
  output ubxffp_pkg::match_t        match
);
  import ubxffp_pkg::*;

  // scan from lowest priority up so the lowest index wins
  always_comb begin
    match = '0;
    for (int i = FILTER_ENTRIES - 1; i >= 0; i--) begin
      if (entries[i].valid && entries[i].cls == cls &&
          (cls == ack_class || entries[i].id == id)) begin
        match.hit = 1'b1;
        match.idx = 2'(i);
      end
    end
  end

endmodule

/* hdl/ubx_frame_filter_parser.sv */
// Top level: byte-wise UBX frame filter, payload streamer and checksum check.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | in_rx_byte
//  out      | out_valid / out_stall| kind, byte, offset, class, id, length, entry
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low; its result, if any, is registered.
// The phase, sums and frame fields update in the cycle the byte is taken.
// A two-entry output buffer (result register plus skid) lets input flow on
// while one result is stalled; in_stall rises only when both entries are full.
// Reset (rst_n low at a clock edge) restores the default registers and
// restarts the search for the first sync byte.
`include "ubx_frame_filter_parser_assert.svh"

module ubx_frame_filter_parser #(
  parameter int FILTER_ENTRIES = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_result_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [15:0]                      out_byte_offset,
  output logic [7:0]                       out_frame_class,
  output logic [7:0]                       out_frame_msg_id,
  output logic [15:0]                      out_frame_length,
  output logic [1:0]                       out_matched_entry,
  input  logic                             cfg_wr_en,
  input  logic [ubxffp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ubxffp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ubxffp_pkg::*;

  logic [7:0]    sync_first_r;
  logic [7:0]    sync_second_r;
  logic [7:0]    ack_class_r;
  filter_entry_t filt_r [FILTER_ENTRIES];

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  msg_id_r, msg_id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  ck_a_r, ck_a_nxt;
  logic [1:0]  hit_r, hit_nxt;

  logic        accept;
  logic        res_v;
  logic        res_fire;
  result_t     res;
  logic [7:0]  sa_add;
  logic [7:0]  sb_add;
  logic [15:0] count_inc;
  match_t      match;

  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    out_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      ack_class_r   <= ACK_CLASS_RST;
      for (int i = 0; i < FILTER_ENTRIES; i++) begin
        filt_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SYNC_FIRST) sync_first_r <= cfg_data[7:0];
      if (cfg_index == REG_SYNC_SECOND) sync_second_r <= cfg_data[7:0];
      if (cfg_index == REG_ACK_CLASS) ack_class_r <= cfg_data[7:0];
      for (int i = 0; i < FILTER_ENTRIES; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_FILTER_0) + i)) begin
          filt_r[i] <= filter_entry_t'(cfg_data);
        end
      end
    end
  end

  ubxffp_match #(
    .FILTER_ENTRIES(FILTER_ENTRIES)
  ) u_match (
    .entries  (filt_r),
    .ack_class(ack_class_r),
    .cls      (class_r),
    .id       (in_rx_byte),
    .match    (match)
  );

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign sa_add    = sum_a_r + in_rx_byte;
  assign sb_add    = sum_b_r + sa_add;
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    msg_id_nxt = msg_id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    ck_a_nxt   = ck_a_r;
    hit_nxt    = hit_r;
    res_v      = 1'b0;
    res        = '0;
    res.cls    = class_r;
    res.id     = msg_id_r;
    res.length = length_r;
    res.entry  = hit_r;
    case (phase_r)
      PH_SYNC2: begin
        if (in_rx_byte == sync_second_r) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          phase_nxt = PH_CLASS;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_nxt = in_rx_byte;
        sum_a_nxt = sa_add;
        sum_b_nxt = sb_add;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        msg_id_nxt = in_rx_byte;
        if (match.hit) begin
          hit_nxt   = match.idx;
          sum_a_nxt = sa_add;
          sum_b_nxt = sb_add;
          phase_nxt = PH_LEN_LO;
        end else begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          phase_nxt = PH_SYNC1;
        end
      end
      PH_LEN_LO: begin
        length_nxt = {8'd0, in_rx_byte};
        sum_a_nxt  = sa_add;
        sum_b_nxt  = sb_add;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = {in_rx_byte, length_r[7:0]};
        sum_a_nxt  = sa_add;
        sum_b_nxt  = sb_add;
        count_nxt  = '0;
        phase_nxt  = (length_nxt == 16'd0) ? PH_CK_A : PH_DATA;
      end
      PH_DATA: begin
        sum_a_nxt  = sa_add;
        sum_b_nxt  = sb_add;
        res_v      = 1'b1;
        res.kind   = KIND_PAYLOAD;
        res.data   = in_rx_byte;
        res.offset = count_r;
        count_nxt  = count_inc;
        if (count_inc >= length_r) phase_nxt = PH_CK_A;
      end
      PH_CK_A: begin
        ck_a_nxt  = in_rx_byte;
        phase_nxt = PH_CK_B;
      end
      PH_CK_B: begin
        res_v     = 1'b1;
        res.kind  = (ck_a_r == sum_a_r && in_rx_byte == sum_b_r) ? KIND_GOOD : KIND_BAD;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        count_nxt = '0;
        phase_nxt = PH_SYNC1;
      end
      default: begin
        phase_nxt = (in_rx_byte == sync_first_r) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  assign res_fire = accept && res_v;

  // frame state: advance on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      class_r  <= '0;
      msg_id_r <= '0;
      length_r <= '0;
      count_r  <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      ck_a_r   <= '0;
      hit_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      msg_id_r <= msg_id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      ck_a_r   <= ck_a_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign out_pop = out_valid_r && !out_stall;

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_pop) begin
      if (res_fire) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= res_fire;
      if (res_fire) out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.kind;
  assign out_payload_byte  = out_r.data;
  assign out_byte_offset   = out_r.offset;
  assign out_frame_class   = out_r.cls;
  assign out_frame_msg_id  = out_r.id;
  assign out_frame_length  = out_r.length;
  assign out_matched_entry = out_r.entry;

  `UBXFFP_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `UBXFFP_ASSERT_IMP(a_data_len_nonzero, clk, rst_n, phase_r == PH_DATA, count_r < length_r)
  `UBXFFP_ASSERT_NXT(a_ckb_restarts, clk, rst_n, accept && phase_r == PH_CK_B, phase_r == PH_SYNC1)
  `UBXFFP_ASSERT_IMP(a_close_no_data, clk, rst_n, out_valid_r && out_r.kind != KIND_PAYLOAD, out_r.data == 8'd0 && out_r.offset == 16'd0)

endmodule

/* bench/tb_ubx_frame_filter_parser.sv */
// Self-checking bench for the UBX frame filter parser: byte stream stimulus, parser model, scoreboard.
module tb_ubx_frame_filter_parser;
  import ubxffp_pkg::*;

  localparam int NUM_FILTERS = 4;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int FLAW_NONE = 0;
  localparam int FLAW_CK_A = 1;
  localparam int FLAW_CK_B = 2;
  localparam int FLAW_SWAP = 3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_result_kind;
  logic [7:0]            out_payload_byte;
  logic [15:0]           out_byte_offset;
  logic [7:0]            out_frame_class;
  logic [7:0]            out_frame_msg_id;
  logic [15:0]           out_frame_length;
  logic [1:0]            out_matched_entry;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ubx_frame_filter_parser #(.FILTER_ENTRIES(NUM_FILTERS)) dut (.*);

  always #4 clk = ~clk;

  // register copies
  logic [7:0]    sync_a_cfg;
  logic [7:0]    sync_b_cfg;
  logic [7:0]    ack_cls_cfg;
  filter_entry_t filter_cfg [NUM_FILTERS];

  // parser state
  logic [3:0]  pr_phase;
  logic [7:0]  pr_class;
  logic [7:0]  pr_id;
  logic [15:0] pr_len;
  logic [15:0] pr_count;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [7:0]  pr_ck_first;
  logic [1:0]  pr_hit;

  logic [7:0]  pending_bytes [$];
  result_t     expected_results [$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned error_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned setups_run = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          in_taken = 1'b0;

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic reset_parser_model();
    sync_a_cfg = SYNC_FIRST_RST;
    sync_b_cfg = SYNC_SECOND_RST;
    ack_cls_cfg = ACK_CLASS_RST;
    foreach (filter_cfg[i]) filter_cfg[i] = '0;
    pr_phase = PH_SYNC1;
    pr_class = '0;
    pr_id = '0;
    pr_len = '0;
    pr_count = '0;
    fl_a = '0;
    fl_b = '0;
    pr_ck_first = '0;
    pr_hit = '0;
  endtask

  function automatic void fletcher_add(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  function automatic result_t frame_result(input logic [1:0] kind, input logic [7:0] data,
                                           input logic [15:0] offs);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.offset = offs;
    r.cls = pr_class;
    r.id = pr_id;
    r.length = pr_len;
    r.entry = pr_hit;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit hit;
    bit emit;
    r = '0;
    hit = 1'b0;
    emit = 1'b0;
    case (pr_phase)
      PH_SYNC2: begin
        if (b == sync_b_cfg) begin
          fl_a = '0;
          fl_b = '0;
          pr_phase = PH_CLASS;
        end else begin
          pr_phase = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        pr_class = b;
        fletcher_add(b);
        pr_phase = PH_ID;
      end
      PH_ID: begin
        pr_id = b;
        for (int i = 0; i < NUM_FILTERS; i++) begin
          if (!hit && filter_cfg[i].valid && filter_cfg[i].cls == pr_class &&
              (filter_cfg[i].cls == ack_cls_cfg || filter_cfg[i].id == pr_id)) begin
            hit = 1'b1;
            pr_hit = 2'(i);
          end
        end
        if (hit) begin
          fletcher_add(b);
          pr_phase = PH_LEN_LO;
        end else begin
          fl_a = '0;
          fl_b = '0;
          pr_phase = PH_SYNC1;
        end
      end
      PH_LEN_LO: begin
        pr_len = {8'h00, b};
        fletcher_add(b);
        pr_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        pr_len[15:8] = b;
        fletcher_add(b);
        pr_count = '0;
        pr_phase = (pr_len == 16'h0000) ? PH_CK_A : PH_DATA;
      end
      PH_DATA: begin
        fletcher_add(b);
        r = frame_result(KIND_PAYLOAD, b, pr_count);
        emit = 1'b1;
        pr_count = pr_count + 16'h0001;
        if (pr_count >= pr_len) pr_phase = PH_CK_A;
      end
      PH_CK_A: begin
        pr_ck_first = b;
        pr_phase = PH_CK_B;
      end
      PH_CK_B: begin
        r = frame_result((pr_ck_first == fl_a && b == fl_b) ? KIND_GOOD : KIND_BAD,
                         8'h00, 16'h0000);
        emit = 1'b1;
        fl_a = '0;
        fl_b = '0;
        pr_count = '0;
        pr_phase = PH_SYNC1;
      end
      default: pr_phase = (b == sync_a_cfg) ? PH_SYNC2 : PH_SYNC1;
    endcase
    return emit;
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input int flaw);
    logic [7:0] hdr [4];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] pl;
    hdr = '{cls, id, len[7:0], len[15:8]};
    ck_a = '0;
    ck_b = '0;
    queue_byte(sync_a_cfg);
    queue_byte(sync_b_cfg);
    foreach (hdr[i]) begin
      queue_byte(hdr[i]);
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
    end
    for (int k = 0; k < int'(len); k++) begin
      pl = 8'($urandom_range(255));
      queue_byte(pl);
      ck_a = ck_a + pl;
      ck_b = ck_b + ck_a;
    end
    case (flaw)
      FLAW_CK_A: ck_a = ck_a ^ 8'($urandom_range(255, 1));
      FLAW_CK_B: ck_b = ck_b ^ 8'($urandom_range(255, 1));
      FLAW_SWAP: {ck_a, ck_b} = {ck_b, ck_a};
      default: ;
    endcase
    queue_byte(ck_a);
    queue_byte(ck_b);
  endtask

  task automatic queue_random_frames(input int unsigned count);
    int unsigned   stop;
    filter_entry_t e;
    logic [7:0]    cls;
    logic [7:0]    id;
    logic [15:0]   len;
    int unsigned   r;
    stop = bytes_queued + count;
    while (bytes_queued < stop) begin
      repeat ($urandom_range(3)) queue_byte(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        queue_byte(sync_a_cfg);
        queue_byte(8'($urandom_range(255)));
      end
      e = filter_cfg[$urandom_range(NUM_FILTERS - 1)];
      if (e.valid && $urandom_range(99) < 85) begin
        cls = e.cls;
        id = (cls == ack_cls_cfg) ? 8'($urandom_range(255)) : e.id;
      end else begin
        cls = 8'($urandom_range(255));
        id = 8'($urandom_range(255));
      end
      r = $urandom_range(99);
      if (r < 10) len = 16'h0000;
      else if (r < 85) len = 16'($urandom_range(12, 1));
      else len = 16'($urandom_range(60, 13));
      queue_frame(cls, id, len,
                  ($urandom_range(99) < 75) ? FLAW_NONE : int'($urandom_range(FLAW_SWAP, 1)));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SYNC_FIRST: sync_a_cfg = val[7:0];
      REG_SYNC_SECOND: sync_b_cfg = val[7:0];
      REG_ACK_CLASS: ack_cls_cfg = val[7:0];
      REG_UNUSED: ;
      default: filter_cfg[2'(idx - REG_FILTER_0)] = val;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_entry();
    filter_entry_t e;
    e.valid = ($urandom_range(9) != 0);
    e.cls = ($urandom_range(3) == 0) ? ack_cls_cfg : 8'($urandom_range(255));
    e.id = 8'($urandom_range(255));
    return e;
  endfunction

  task automatic load_setup(input int setup);
    case (setup)
      0: begin
        write_reg(REG_SYNC_FIRST, CFG_DATA_W'(SYNC_FIRST_RST));
        write_reg(REG_SYNC_SECOND, CFG_DATA_W'(SYNC_SECOND_RST));
        write_reg(REG_ACK_CLASS, CFG_DATA_W'(ACK_CLASS_RST));
        write_reg(REG_UNUSED, '1);
      end
      1: begin
        write_reg(REG_SYNC_FIRST, 17'h00000);
        write_reg(REG_SYNC_SECOND, 17'h000FF);
        write_reg(REG_ACK_CLASS, 17'h000FF);
      end
      2: begin
        write_reg(REG_SYNC_FIRST, 17'h000FF);
        write_reg(REG_SYNC_SECOND, 17'h00000);
        write_reg(REG_ACK_CLASS, 17'h00000);
      end
      default: begin
        write_reg(REG_SYNC_FIRST, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_SYNC_SECOND, CFG_DATA_W'($urandom_range(255)));
        write_reg(REG_ACK_CLASS, CFG_DATA_W'($urandom_range(255)));
      end
    endcase
    for (int i = 0; i < NUM_FILTERS; i++) begin
      write_reg(CFG_IDX_W'(int'(REG_FILTER_0) + i), random_entry());
    end
    if (setup == 1) write_reg(REG_FILTER_0, '1);
    if (setup == 2) begin
      write_reg(REG_FILTER_0, {1'b1, 8'h00, 8'h00});
      write_reg(CFG_IDX_W'(int'(REG_FILTER_0) + 1), '0);
    end
    setups_run++;
  endtask

  task automatic settle();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_bytes
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_valid;
    nxt_byte = in_rx_byte;
    if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_valid = 1'b1;
        nxt_byte = pending_bytes.pop_front();
      end
    end
    in_valid <= nxt_valid;
    in_rx_byte <= nxt_byte;
  end

  always @(negedge clk) begin : drive_stall
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    logic    took_out;
    if (rst_n) begin
      in_taken = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (in_taken) begin
        bytes_taken++;
        if (parse_byte(in_rx_byte, want)) expected_results.push_back(want);
      end
      if (took_out) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing pending, kind %0d", out_result_kind));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", out_result_kind, want.kind);
          check_field("payload byte", out_payload_byte, want.data);
          check_field("byte offset", out_byte_offset, want.offset);
          check_field("class", out_frame_class, want.cls);
          check_field("msg id", out_frame_msg_id, want.id);
          check_field("length", out_frame_length, want.length);
          check_field("matched entry", out_matched_entry, want.entry);
          if (want.kind == KIND_GOOD) frames_good++;
          if (want.kind == KIND_BAD) frames_bad++;
        end
      end
      stuck_cycles = (in_taken || took_out) ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    reset_parser_model();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(REG_FILTER_0, {1'b1, 8'h01, 8'h07});
    write_reg(CFG_IDX_W'(int'(REG_FILTER_0) + 1), {1'b1, 8'h01, 8'h07});
    write_reg(CFG_IDX_W'(int'(REG_FILTER_0) + 2), {1'b1, ACK_CLASS_RST, 8'h00});
    write_reg(CFG_IDX_W'(int'(REG_FILTER_0) + 3), {1'b1, 8'h0A, 8'h04});

    // broken sync, then overlapping entries, ack class, bad sum, dropped frame
    queue_byte(sync_a_cfg);
    queue_byte(8'h00);
    queue_byte(sync_b_cfg);
    queue_frame(8'h01, 8'h07, 16'h0000, FLAW_NONE);
    queue_frame(ACK_CLASS_RST, 8'hFF, 16'h0001, FLAW_CK_A);
    queue_byte(sync_a_cfg);
    queue_byte(sync_b_cfg);
    queue_byte(8'h01);
    queue_byte(8'h08);
    settle();

    queue_frame(8'h0A, 8'h04, 16'h0102, FLAW_NONE);
    settle();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      load_setup(mode);
      queue_random_frames(170);
      settle();
      queue_random_frames(170);
      settle();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Covered %0d bytes and %0d results (%0d good frames, %0d checksum errors)",
             bytes_taken, results_seen, frames_good, frames_bad);
    $display("over %0d register setups and four idle/stall mixes, %0d errors",
             setups_run, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/ubxffp_pkg.sv
hdl/ubxffp_match.sv
hdl/ubx_frame_filter_parser.sv
bench/tb_ubx_frame_filter_parser.sv
